// ===== rtl/fhrp_pkg.sv =====
package fhrp_pkg;

   // The magic word as it reads when its four bytes are gathered little-endian.
   localparam logic [31:0] MAGIC_WORD = 32'h5746_494F;

   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   typedef enum logic [3:0] {
      PH_MAGIC  = 4'd0,
      PH_HSIZE  = 4'd1,
      PH_PHDR   = 4'd2,
      PH_PNAME  = 4'd3,
      PH_PVAL   = 4'd4,
      PH_BNSIZE = 4'd5,
      PH_BOFF   = 4'd6,
      PH_BSIZE  = 4'd7,
      PH_BNAME  = 4'd8,
      PH_QHDR   = 4'd9,
      PH_QNAME  = 4'd10,
      PH_QVAL   = 4'd11,
      PH_DONE   = 4'd12,
      PH_BAD    = 4'd13
   } phase_type;

   typedef enum logic [2:0] {
      EV_PROP  = 3'd0,
      EV_BLOCK = 3'd1,
      EV_BPROP = 3'd2,
      EV_MAGIC = 3'd3,
      EV_END   = 3'd4,
      EV_TRUNC = 3'd5
   } event_kind_type;

   typedef struct packed {
      event_kind_type kind;
      logic [31:0]    name_length;
      logic [31:0]    value_length;
      logic [63:0]    block_offset;
      logic [63:0]    block_length;
      logic [31:0]    name_position;
      logic           name_printable;
      logic           last_result;
   } result_type;

   function automatic result_type make_event(event_kind_type kind);
      result_type r;
      r = '0;
      r.kind = kind;
      return r;
   endfunction

endpackage

// ===== rtl/firmware_header_record_parser_core.sv =====
// Channel  | Direction | Handshake                  | Payload
// req_     | in        | req_valid / req_stall      | data_byte, last_byte
// rsp_     | out       | rsp_valid / rsp_stall      | one record or status event
//
// Each byte is parsed in the cycle it is accepted, so one byte is taken per cycle while req_stall is low.
// A byte yields at most two events; they go into a four-entry result queue, and
// req_stall rises once fewer than two queue entries are free.
// An event is registered in the result queue and can reach rsp_ in the cycle after its byte.
// Synchronous reset returns the parser to the magic check and empties the queue.
module firmware_header_record_parser_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_event_kind,
   output logic [31:0] rsp_name_length,
   output logic [31:0] rsp_value_length,
   output logic [63:0] rsp_block_offset,
   output logic [63:0] rsp_block_length,
   output logic [31:0] rsp_name_position,
   output logic        rsp_name_printable,
   output logic        rsp_last_result
);

   fhrp_pkg::phase_type phase_ff, phase_in;
   logic [31:0] pos_ff, pos_in;
   logic [31:0] hlen_ff, hlen_in;
   logic [63:0] shift_ff, shift_in;
   logic [3:0]  fcount_ff, fcount_in;
   logic [31:0] nsize_ff, nsize_in;
   logic [31:0] vsize_ff, vsize_in;
   logic [63:0] off_ff, off_in;
   logic [63:0] size_ff, size_in;
   logic [31:0] skip_ff, skip_in;
   logic        name_ok_ff, name_ok_in;
   logic        nul_ff, nul_in;
   logic [31:0] nstart_ff, nstart_in;

   fhrp_pkg::result_type fifo_ff [fhrp_pkg::RSP_DEPTH];
   logic [fhrp_pkg::RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [fhrp_pkg::RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [fhrp_pkg::RSP_CNT_W-1:0] count_ff, count_in;

   logic        accept;
   logic        pop;
   logic [31:0] next_pos;
   logic [63:0] take_shift;
   logic [3:0]  take_cnt;
   logic        done4, done8;
   logic        name_ok_upd, nul_upd;
   logic [31:0] skip_dec;
   logic        skip_done;
   logic        do_open;
   fhrp_pkg::phase_type open_phase;
   logic        rec_valid, end_valid, trunc;
   fhrp_pkg::result_type rec, res0, res1;
   logic [1:0]  push_n;

   assign accept    = req_valid && !req_stall;
   assign pop       = (count_ff != '0) && !rsp_stall;
   assign req_stall = count_ff > fhrp_pkg::RSP_CNT_W'(fhrp_pkg::RSP_DEPTH - 2);
   assign next_pos  = pos_ff + 32'd1;

   // Field gathering: the byte lands in the lane given by the bytes already taken.
   always_comb begin
      take_shift = shift_ff;
      for (int i = 0; i < 8; i++) begin
         if (fcount_ff[2:0] == 3'(i)) begin
            take_shift[8*i +: 8] = shift_ff[8*i +: 8] | req_data_byte;
         end
      end
      take_cnt = fcount_ff + 4'd1;
      done4    = take_cnt >= 4'd4;
      done8    = take_cnt >= 4'd8;
   end

   // Name bytes are checked only up to the first NUL.
   always_comb begin
      name_ok_upd = name_ok_ff;
      nul_upd     = nul_ff;
      if (!nul_ff) begin
         if (req_data_byte == 8'h00) begin
            nul_upd = 1'b1;
         end else if (req_data_byte < 8'h21 || req_data_byte > 8'h7E) begin
            name_ok_upd = 1'b0;
         end
      end
      skip_dec  = (skip_ff != 32'd0) ? skip_ff - 32'd1 : 32'd0;
      skip_done = skip_dec == 32'd0;
   end

   always_comb begin
      phase_in   = phase_ff;
      pos_in     = next_pos;
      hlen_in    = hlen_ff;
      shift_in   = shift_ff;
      fcount_in  = fcount_ff;
      nsize_in   = nsize_ff;
      vsize_in   = vsize_ff;
      off_in     = off_ff;
      size_in    = size_ff;
      skip_in    = skip_ff;
      name_ok_in = name_ok_ff;
      nul_in     = nul_ff;
      nstart_in  = nstart_ff;
      do_open    = 1'b0;
      open_phase = fhrp_pkg::PH_PHDR;
      rec_valid  = 1'b0;
      end_valid  = 1'b0;
      rec        = fhrp_pkg::make_event(fhrp_pkg::EV_PROP);

      unique case (phase_ff)
         fhrp_pkg::PH_MAGIC: begin
            shift_in  = take_shift;
            fcount_in = take_cnt;
            if (done4) begin
               shift_in  = '0;
               fcount_in = '0;
               if (take_shift[31:0] == fhrp_pkg::MAGIC_WORD) begin
                  phase_in = fhrp_pkg::PH_HSIZE;
               end else begin
                  phase_in  = fhrp_pkg::PH_BAD;
                  rec_valid = 1'b1;
                  rec       = fhrp_pkg::make_event(fhrp_pkg::EV_MAGIC);
               end
            end
         end
         fhrp_pkg::PH_HSIZE: begin
            shift_in  = take_shift;
            fcount_in = take_cnt;
            if (done4) begin
               hlen_in    = take_shift[31:0];
               do_open    = 1'b1;
               open_phase = fhrp_pkg::PH_PHDR;
            end
         end
         fhrp_pkg::PH_PHDR, fhrp_pkg::PH_QHDR: begin
            shift_in  = take_shift;
            fcount_in = take_cnt;
            if (done8) begin
               nsize_in  = take_shift[31:0];
               vsize_in  = take_shift[63:32];
               shift_in  = '0;
               fcount_in = '0;
               if (take_shift[31:0] == 32'd0) begin
                  // Either property list closing leads on to the block list.
                  do_open    = 1'b1;
                  open_phase = fhrp_pkg::PH_BNSIZE;
               end else begin
                  skip_in    = take_shift[31:0];
                  nstart_in  = next_pos;
                  name_ok_in = 1'b1;
                  nul_in     = 1'b0;
                  phase_in   = (phase_ff == fhrp_pkg::PH_PHDR) ? fhrp_pkg::PH_PNAME
                                                               : fhrp_pkg::PH_QNAME;
               end
            end
         end
         fhrp_pkg::PH_PNAME, fhrp_pkg::PH_QNAME: begin
            name_ok_in = name_ok_upd;
            nul_in     = nul_upd;
            skip_in    = skip_dec;
            if (skip_done) begin
               rec_valid = 1'b1;
               if (phase_ff == fhrp_pkg::PH_PNAME) begin
                  rec = fhrp_pkg::make_event(fhrp_pkg::EV_PROP);
               end else begin
                  rec              = fhrp_pkg::make_event(fhrp_pkg::EV_BPROP);
                  rec.block_offset = off_ff;
                  rec.block_length = size_ff;
               end
               rec.name_length    = nsize_ff;
               rec.value_length   = vsize_ff;
               rec.name_position  = nstart_ff;
               rec.name_printable = name_ok_upd;
               if (vsize_ff == 32'd0) begin
                  do_open    = 1'b1;
                  open_phase = (phase_ff == fhrp_pkg::PH_PNAME) ? fhrp_pkg::PH_PHDR
                                                                : fhrp_pkg::PH_QHDR;
               end else begin
                  skip_in  = vsize_ff;
                  phase_in = (phase_ff == fhrp_pkg::PH_PNAME) ? fhrp_pkg::PH_PVAL
                                                              : fhrp_pkg::PH_QVAL;
               end
            end
         end
         fhrp_pkg::PH_PVAL: begin
            skip_in = skip_dec;
            if (skip_done) begin
               do_open    = 1'b1;
               open_phase = fhrp_pkg::PH_PHDR;
            end
         end
         fhrp_pkg::PH_QVAL: begin
            skip_in = skip_dec;
            if (skip_done) begin
               do_open    = 1'b1;
               open_phase = fhrp_pkg::PH_QHDR;
            end
         end
         fhrp_pkg::PH_BNSIZE: begin
            shift_in  = take_shift;
            fcount_in = take_cnt;
            if (done4) begin
               nsize_in  = take_shift[31:0];
               shift_in  = '0;
               fcount_in = '0;
               phase_in  = fhrp_pkg::PH_BOFF;
            end
         end
         fhrp_pkg::PH_BOFF: begin
            shift_in  = take_shift;
            fcount_in = take_cnt;
            if (done8) begin
               off_in    = take_shift;
               shift_in  = '0;
               fcount_in = '0;
               phase_in  = fhrp_pkg::PH_BSIZE;
            end
         end
         fhrp_pkg::PH_BSIZE: begin
            shift_in  = take_shift;
            fcount_in = take_cnt;
            if (done8) begin
               size_in   = take_shift;
               shift_in  = '0;
               fcount_in = '0;
               if (nsize_ff == 32'd0) begin
                  phase_in  = fhrp_pkg::PH_DONE;
                  end_valid = 1'b1;
               end else begin
                  skip_in    = nsize_ff;
                  nstart_in  = next_pos;
                  name_ok_in = 1'b1;
                  nul_in     = 1'b0;
                  phase_in   = fhrp_pkg::PH_BNAME;
               end
            end
         end
         fhrp_pkg::PH_BNAME: begin
            name_ok_in = name_ok_upd;
            nul_in     = nul_upd;
            skip_in    = skip_dec;
            if (skip_done) begin
               rec_valid          = 1'b1;
               rec                = fhrp_pkg::make_event(fhrp_pkg::EV_BLOCK);
               rec.name_length    = nsize_ff;
               rec.block_offset   = off_ff;
               rec.block_length   = size_ff;
               rec.name_position  = nstart_ff;
               rec.name_printable = name_ok_upd;
               do_open            = 1'b1;
               open_phase         = fhrp_pkg::PH_QHDR;
            end
         end
         default: begin
         end
      endcase

      // A record may only start below the header end; otherwise parsing stops.
      if (do_open) begin
         shift_in  = '0;
         fcount_in = '0;
         if (next_pos >= hlen_in) begin
            phase_in  = fhrp_pkg::PH_DONE;
            end_valid = 1'b1;
         end else begin
            phase_in = open_phase;
         end
      end

      trunc = req_last_byte && (phase_in <= fhrp_pkg::PH_QVAL);

      if (req_last_byte) begin
         phase_in   = fhrp_pkg::PH_MAGIC;
         pos_in     = '0;
         hlen_in    = '0;
         shift_in   = '0;
         fcount_in  = '0;
         nsize_in   = '0;
         vsize_in   = '0;
         off_in     = '0;
         size_in    = '0;
         skip_in    = '0;
         name_ok_in = 1'b1;
         nul_in     = 1'b0;
         nstart_in  = '0;
      end
   end

   // Order the events of one byte: record event, then header end or truncation.
   always_comb begin
      res0   = rec;
      res1   = fhrp_pkg::make_event(fhrp_pkg::EV_TRUNC);
      push_n = 2'd0;
      if (rec_valid) begin
         if (end_valid) begin
            res1   = fhrp_pkg::make_event(fhrp_pkg::EV_END);
            push_n = 2'd2;
         end else if (trunc) begin
            push_n = 2'd2;
         end else begin
            push_n = 2'd1;
         end
      end else if (end_valid) begin
         res0   = fhrp_pkg::make_event(fhrp_pkg::EV_END);
         push_n = 2'd1;
      end else if (trunc) begin
         res0   = fhrp_pkg::make_event(fhrp_pkg::EV_TRUNC);
         push_n = 2'd1;
      end
      res0.last_result = push_n == 2'd1;
      res1.last_result = 1'b1;
      if (!accept) begin
         push_n = 2'd0;
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff + fhrp_pkg::RSP_PTR_W'(push_n);
      rd_ptr_in = rd_ptr_ff + fhrp_pkg::RSP_PTR_W'(pop);
      count_in  = count_ff + fhrp_pkg::RSP_CNT_W'(push_n) - fhrp_pkg::RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= fhrp_pkg::PH_MAGIC;
         pos_ff     <= '0;
         hlen_ff    <= '0;
         shift_ff   <= '0;
         fcount_ff  <= '0;
         nsize_ff   <= '0;
         vsize_ff   <= '0;
         off_ff     <= '0;
         size_ff    <= '0;
         skip_ff    <= '0;
         name_ok_ff <= 1'b1;
         nul_ff     <= 1'b0;
         nstart_ff  <= '0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         pos_ff     <= pos_in;
         hlen_ff    <= hlen_in;
         shift_ff   <= shift_in;
         fcount_ff  <= fcount_in;
         nsize_ff   <= nsize_in;
         vsize_ff   <= vsize_in;
         off_ff     <= off_in;
         size_ff    <= size_in;
         skip_ff    <= skip_in;
         name_ok_ff <= name_ok_in;
         nul_ff     <= nul_in;
         nstart_ff  <= nstart_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         fifo_ff[wr_ptr_ff] <= res0;
      end
      if (push_n == 2'd2) begin
         fifo_ff[wr_ptr_ff + fhrp_pkg::RSP_PTR_W'(1)] <= res1;
      end
   end

   assign rsp_valid          = count_ff != '0;
   assign rsp_event_kind     = fifo_ff[rd_ptr_ff].kind;
   assign rsp_name_length    = fifo_ff[rd_ptr_ff].name_length;
   assign rsp_value_length   = fifo_ff[rd_ptr_ff].value_length;
   assign rsp_block_offset   = fifo_ff[rd_ptr_ff].block_offset;
   assign rsp_block_length   = fifo_ff[rd_ptr_ff].block_length;
   assign rsp_name_position  = fifo_ff[rd_ptr_ff].name_position;
   assign rsp_name_printable = fifo_ff[rd_ptr_ff].name_printable;
   assign rsp_last_result    = fifo_ff[rd_ptr_ff].last_result;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= fhrp_pkg::RSP_CNT_W'(fhrp_pkg::RSP_DEPTH))
      else $error("result queue count beyond its depth");

   a_rearm: assert property (@(posedge clock) disable iff (reset)
      accept && req_last_byte |=> phase_ff == fhrp_pkg::PH_MAGIC && pos_ff == 32'd0)
      else $error("parser did not rearm after the final byte");

   a_quiet_after_end: assert property (@(posedge clock) disable iff (reset)
      accept && (phase_ff == fhrp_pkg::PH_DONE || phase_ff == fhrp_pkg::PH_BAD)
      |-> push_n == 2'd0)
      else $error("event produced after parsing had ended");

   a_room_for_two: assert property (@(posedge clock) disable iff (reset)
      accept |-> count_ff <= fhrp_pkg::RSP_CNT_W'(fhrp_pkg::RSP_DEPTH - 2))
      else $error("item taken without room for two events");

endmodule
